### rtl/wtbl_pkg.sv
// Shared types, constants and a helper function of the windowed token bucket limiter.
package wtbl_pkg;

  localparam int USERS_DEFAULT = 64;
  localparam int INDEX_W       = 6;
  localparam int TIME_W        = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_TABLE     = 1 << INDEX_W;
  localparam int PROD_W        = TIME_W + CFG_W;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_TOKENS  = 2'd2;

  localparam logic [CFG_W-1:0] BUCKET_SIZE_RESET    = 16'd10;
  localparam logic [CFG_W-1:0] WINDOW_SECONDS_RESET = 16'd1;
  localparam logic [CFG_W-1:0] REFILL_TOKENS_RESET  = 16'd5;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    logic [CFG_W-1:0]   tokens;
    logic [TIME_W-1:0]  start;
  } tbl_wr_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [CFG_W-1:0] floor_minus_one(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

endpackage

### rtl/wtbl_divider.sv
// Iterative restoring divider that produces one quotient bit per cycle.
module wtbl_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wtbl_pkg::div_req_t           req,
  output wtbl_pkg::div_sts_t           sts,
  output logic [wtbl_pkg::TIME_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(wtbl_pkg::TIME_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wtbl_pkg::TIME_W - 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [wtbl_pkg::TIME_W-1:0] q_r;
  logic [wtbl_pkg::CFG_W-1:0]  rem_r;
  logic [wtbl_pkg::CFG_W-1:0]  divisor_r;
  logic [wtbl_pkg::CFG_W:0]    trial;
  logic                        take;
  logic [wtbl_pkg::CFG_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[wtbl_pkg::TIME_W-1]};
    take    = trial >= {1'b0, divisor_r};
    rem_nxt = take ? wtbl_pkg::CFG_W'(trial - {1'b0, divisor_r})
                   : trial[wtbl_pkg::CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        q_r       <= req.dividend;
        rem_r     <= '0;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[wtbl_pkg::TIME_W-2:0], take};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < divisor_r))
    else $error("Divider remainder reached the divisor.");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("Divider flagged done while still iterating.");
`endif

endmodule

### rtl/wtbl_user_table.sv
// Per-user table of token counts and window starts with seen flags.
module wtbl_user_table #(
  parameter int DEPTH = wtbl_pkg::MAX_TABLE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wtbl_pkg::INDEX_W-1:0]  rd_addr,
  output logic                          rd_seen,
  output logic [wtbl_pkg::CFG_W-1:0]    rd_tokens,
  output logic [wtbl_pkg::TIME_W-1:0]   rd_start,
  input  wtbl_pkg::tbl_wr_t             wr
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [wtbl_pkg::CFG_W-1:0]  tokens_mem [DEPTH];
  logic [wtbl_pkg::TIME_W-1:0] start_mem  [DEPTH];
  logic [DEPTH-1:0]            seen_r;
  logic [AW-1:0]               ra;
  logic [AW-1:0]               wa;

  assign ra = rd_addr[AW-1:0];
  assign wa = wr.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tokens_mem[wa] <= wr.tokens;
      start_mem[wa]  <= wr.start;
    end
    rd_tokens <= tokens_mem[ra];
    rd_start  <= start_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      rd_seen <= 1'b0;
    end else begin
      if (wr.en) begin
        seen_r[wa] <= 1'b1;
      end
      rd_seen <= seen_r[ra];
    end
  end

endmodule

### rtl/windowed_token_bucket_limiter.sv
// Top level of the windowed token bucket limiter: sequencer, registers and output stage.
//
// Each input transaction carries a user index and the current time in seconds;
// each one produces exactly one output transaction with the grant decision.
// The input channel takes a transaction only while the sequencer is idle, so
// in_stall is high while a request is being worked on. After acceptance, an
// index at or beyond USERS goes straight to the output stage, a request from a
// new user passes through the table lookup first and a request inside the
// current window through the lookup and the window check. A request that needs
// a refill runs the 32-step divider to count the elapsed windows and then two
// passes through the shared multiplier before its result is loaded. The next
// request can be accepted in the cycle after its result is loaded.
// The result sits in an output register, so the next request is accepted while
// it waits; if out_stall stays high the sequencer holds its finished result
// until the register frees up.
// Configuration writes through cfg_wr_en take effect at the next clock edge.
// Synchronous reset restores the default bucket size, window and refill,
// forgets every user and empties the output register.
module windowed_token_bucket_limiter #(
  parameter int USERS = wtbl_pkg::USERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wtbl_pkg::INDEX_W-1:0]   in_user_index,
  input  logic [wtbl_pkg::TIME_W-1:0]    in_now_seconds,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_granted,
  input  logic                           cfg_wr_en,
  input  logic [wtbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtbl_pkg::CFG_W-1:0]     cfg_data
);

  localparam int TABLE_DEPTH = (USERS < wtbl_pkg::MAX_TABLE) ? USERS : wtbl_pkg::MAX_TABLE;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_MUL_R = 3'd4;
  localparam logic [2:0] ST_MUL_W = 3'd5;
  localparam logic [2:0] ST_UPD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]                    state_r;
  logic [wtbl_pkg::INDEX_W-1:0]  idx_r;
  logic [wtbl_pkg::TIME_W-1:0]   now_r;
  logic [wtbl_pkg::CFG_W-1:0]    tok_r;
  logic [wtbl_pkg::TIME_W-1:0]   start_r;
  logic [wtbl_pkg::TIME_W-1:0]   elapsed_r;
  logic [wtbl_pkg::TIME_W-1:0]   windows_r;
  logic [wtbl_pkg::PROD_W-1:0]   prod_r;
  logic [wtbl_pkg::CFG_W-1:0]    tok_new_r;
  logic                          res_r;
  logic                          out_valid_r;
  logic                          out_granted_r;
  logic [wtbl_pkg::CFG_W-1:0]    bucket_r;
  logic [wtbl_pkg::CFG_W-1:0]    window_r;
  logic [wtbl_pkg::CFG_W-1:0]    refill_r;

  logic                          in_accept;
  logic                          in_range;
  logic [wtbl_pkg::CFG_W-1:0]    win_eff;
  logic                          in_window;
  logic                          out_load;
  logic [wtbl_pkg::TIME_W-1:0]   mul_a;
  logic [wtbl_pkg::CFG_W-1:0]    mul_b;
  logic [wtbl_pkg::PROD_W:0]     sum;
  logic [wtbl_pkg::CFG_W-1:0]    capped;
  logic                          rd_seen;
  logic [wtbl_pkg::CFG_W-1:0]    rd_tokens;
  logic [wtbl_pkg::TIME_W-1:0]   rd_start;
  logic [wtbl_pkg::TIME_W-1:0]   div_q;
  wtbl_pkg::tbl_wr_t             tbl_wr;
  wtbl_pkg::div_req_t            div_req;
  wtbl_pkg::div_sts_t            div_sts;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = (32'(in_user_index) < 32'(USERS));
  assign win_eff   = (window_r == '0) ? wtbl_pkg::CFG_W'(1) : window_r;
  assign in_window = (elapsed_r <= wtbl_pkg::TIME_W'(win_eff));
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  assign mul_a = windows_r;
  assign mul_b = (state_r == ST_MUL_W) ? win_eff : refill_r;

  always_comb begin
    sum    = {1'b0, prod_r} + (wtbl_pkg::PROD_W + 1)'(tok_r);
    capped = (sum < (wtbl_pkg::PROD_W + 1)'(bucket_r)) ? sum[wtbl_pkg::CFG_W-1:0] : bucket_r;
  end

  always_comb begin
    tbl_wr.en     = 1'b0;
    tbl_wr.addr   = idx_r;
    tbl_wr.tokens = tok_new_r;
    tbl_wr.start  = start_r + prod_r[wtbl_pkg::TIME_W-1:0];
    unique case (state_r)
      ST_LOOK: begin
        tbl_wr.en     = !rd_seen;
        tbl_wr.tokens = wtbl_pkg::floor_minus_one(bucket_r);
        tbl_wr.start  = now_r;
      end
      ST_CHECK: begin
        tbl_wr.en     = in_window && (tok_r != '0);
        tbl_wr.tokens = tok_r - 1'b1;
        tbl_wr.start  = start_r;
      end
      ST_UPD: begin
        tbl_wr.en = 1'b1;
      end
      default: begin
        tbl_wr.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = (state_r == ST_CHECK) && !in_window;
    div_req.dividend = elapsed_r - 1'b1;
    div_req.divisor  = win_eff;
  end

  wtbl_user_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (in_user_index),
    .rd_seen   (rd_seen),
    .rd_tokens (rd_tokens),
    .rd_start  (rd_start),
    .wr        (tbl_wr)
  );

  wtbl_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .sts      (div_sts),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= wtbl_pkg::PROD_W'(mul_a) * wtbl_pkg::PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r <= wtbl_pkg::BUCKET_SIZE_RESET;
      window_r <= wtbl_pkg::WINDOW_SECONDS_RESET;
      refill_r <= wtbl_pkg::REFILL_TOKENS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wtbl_pkg::REG_BUCKET_SIZE:    bucket_r <= cfg_data;
        wtbl_pkg::REG_WINDOW_SECONDS: window_r <= cfg_data;
        wtbl_pkg::REG_REFILL_TOKENS:  refill_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r   <= 1'b1;
        out_granted_r <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            idx_r <= in_user_index;
            now_r <= in_now_seconds;
            if (in_range) begin
              state_r <= ST_LOOK;
            end else begin
              res_r   <= 1'b0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_LOOK: begin
          tok_r     <= rd_tokens;
          start_r   <= rd_start;
          elapsed_r <= now_r - rd_start;
          if (!rd_seen) begin
            res_r   <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (in_window) begin
            res_r   <= (tok_r != '0);
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_sts.done) begin
            windows_r <= div_q;
            state_r   <= ST_MUL_R;
          end
        end
        ST_MUL_R: begin
          state_r <= ST_MUL_W;
        end
        ST_MUL_W: begin
          tok_new_r <= wtbl_pkg::floor_minus_one(capped);
          state_r   <= ST_UPD;
        end
        ST_UPD: begin
          res_r   <= 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;

`ifndef ASSERT_OFF
  a_out_of_range_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_range) |=> (state_r == ST_OUT))
    else $error("Out-of-range user did not go straight to the output stage.");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> (state_r == ST_LOOK || state_r == ST_CHECK || state_r == ST_UPD))
    else $error("User table written outside an update step.");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_sts.busy)
    else $error("Divider started while a division was in progress.");
`endif

endmodule
